FILE: rtl/cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// shared constants and types for the cycle profile statistics core
// ----------------------------------------------------------------------------
package cps_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_W     = 4;
	localparam int BAR_STEPS  = 20;
	localparam int BAR_W      = 5;
	localparam int PERCENT    = 100;
	localparam int SCALE_DOWN = 16;
	localparam int SCALE_UP   = 32;

	typedef enum logic {
		OP_CLEAR  = 1'b0,
		OP_RECORD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		UOP_DIV,
		UOP_SQRT
	} uop_t;

	typedef struct packed {
		logic        start;
		uop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_MEAN,
		ST_MSQ,
		ST_M2,
		ST_SD,
		ST_CPB,
		ST_CVMUL,
		ST_CV,
		ST_BARMUL,
		ST_BAR,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/cycle_profile_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_profile_statistics_core
// per-slot cycle statistics with mean, deviation, cost and bar position
// ----------------------------------------------------------------------------
// One item is taken at a time and produces one result. A clear, or a record
// into an unloaded slot, goes through the update, square-multiply and
// square-accumulate states to the output state. A record into a loaded slot
// also runs the single shared divide/square-root unit: four 64-step divisions
// (mean, mean square, cost per byte, variation) and, when the bar applies, a
// fifth, plus one 32-step square root. A result waits in an output register
// until taken; the next item is accepted the cycle after it is taken.
module cycle_profile_statistics_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [3:0]  slot,
	input  logic [63:0] cycle_sample,
	input  logic [31:0] code_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [63:0] call_total,
	output logic [63:0] mean_cycles,
	output logic [63:0] min_seen,
	output logic [63:0] max_seen,
	output logic [31:0] std_deviation,
	output logic [63:0] cost_per_byte,
	output logic [63:0] variation_percent,
	output logic [4:0]  bar_position,
	output logic [63:0] all_calls
);

	logic        loaded_q [cps_pkg::NUM_SLOTS];
	logic [63:0] count_q  [cps_pkg::NUM_SLOTS];
	logic [63:0] sum_q    [cps_pkg::NUM_SLOTS];
	logic [63:0] sqsum_q  [cps_pkg::NUM_SLOTS];
	logic [63:0] min_q    [cps_pkg::NUM_SLOTS];
	logic [63:0] max_q    [cps_pkg::NUM_SLOTS];
	logic [31:0] size_q   [cps_pkg::NUM_SLOTS];
	logic [63:0] gcalls_q;

	cps_pkg::state_t state_q, state_d;
	logic        op_q;
	logic [3:0]  slot_q;
	logic [63:0] sample_q;
	logic [31:0] bytes_q;
	logic        status_q;
	logic [63:0] cnt_q, sum_q2, sq_q, mn_q, mx_q, mean_q, msq_q, m2_q, tmp_q;
	logic [31:0] sd_q, sz_q;
	logic [63:0] cpb_q, cv_q;
	logic [4:0]  bar_q;
	logic        out_valid_q;
	logic        wait_q;

	cps_pkg::unit_req_t req;
	cps_pkg::unit_rsp_t rsp;

	cps_unit u_unit (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        bar_ok;

	always_comb begin
		mul_a = sample_q[31:0];
		mul_b = sample_q[31:0];
		if (sample_q[63:32] != '0) begin
			mul_a = sample_q[47:16];
			mul_b = sample_q[47:16];
		end
		if (state_q == cps_pkg::ST_M2) begin
			mul_a = mean_q[31:0];
			mul_b = mean_q[31:0];
		end
		mul_p = 64'(mul_a) * 64'(mul_b);
		bar_ok = (mx_q > mn_q) && (mx_q != '0) && (mean_q >= mn_q) && (mean_q <= mx_q);
	end

	// full 64-bit wrap of mean*mean: low halves product plus cross term
	logic [63:0] m2_full;
	always_comb begin
		m2_full = mul_p + {(mean_q[63:32] * mean_q[31:0]) << 1, 32'b0} ;
	end

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.op    = cps_pkg::UOP_DIV;
		req.a     = '0;
		req.b     = '0;
		unique case (state_q)
			cps_pkg::ST_IDLE:   if (in_valid && in_ready) state_d = cps_pkg::ST_UPDATE;
			cps_pkg::ST_UPDATE: state_d = cps_pkg::ST_SQ_MUL;
			cps_pkg::ST_SQ_MUL: state_d = cps_pkg::ST_SQ_ACC;
			cps_pkg::ST_SQ_ACC:
				state_d = (count_q[slot_q] == '0) ? cps_pkg::ST_OUT : cps_pkg::ST_MEAN;
			cps_pkg::ST_MEAN: begin
				req.start = !wait_q; req.a = sum_q2; req.b = cnt_q;
				if (rsp.done) state_d = cps_pkg::ST_MSQ;
			end
			cps_pkg::ST_MSQ: begin
				req.start = !wait_q; req.a = sq_q; req.b = cnt_q;
				if (rsp.done) state_d = cps_pkg::ST_M2;
			end
			cps_pkg::ST_M2: state_d = cps_pkg::ST_SD;
			cps_pkg::ST_SD: begin
				req.start = !wait_q; req.op = cps_pkg::UOP_SQRT;
				req.a = (msq_q >= m2_q) ? msq_q - m2_q : '0;
				if (rsp.done) state_d = cps_pkg::ST_CPB;
			end
			cps_pkg::ST_CPB: begin
				req.start = !wait_q; req.a = mean_q; req.b = 64'(sz_q);
				if (rsp.done) state_d = cps_pkg::ST_CVMUL;
			end
			cps_pkg::ST_CVMUL: state_d = cps_pkg::ST_CV;
			cps_pkg::ST_CV: begin
				req.start = !wait_q; req.a = tmp_q; req.b = mean_q;
				if (rsp.done) state_d = bar_ok ? cps_pkg::ST_BARMUL : cps_pkg::ST_OUT;
			end
			cps_pkg::ST_BARMUL: state_d = cps_pkg::ST_BAR;
			cps_pkg::ST_BAR: begin
				req.start = !wait_q; req.a = tmp_q; req.b = mx_q - mn_q;
				if (rsp.done) state_d = cps_pkg::ST_OUT;
			end
			cps_pkg::ST_OUT:    if (!out_valid_q || out_ready) state_d = cps_pkg::ST_IDLE;
			default:            state_d = cps_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == cps_pkg::ST_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			wait_q      <= 1'b0;
			gcalls_q    <= '0;
			for (int i = 0; i < cps_pkg::NUM_SLOTS; i++) begin
				loaded_q[i] <= 1'b0;
				count_q[i]  <= '0;
				sum_q[i]    <= '0;
				sqsum_q[i]  <= '0;
				min_q[i]    <= '1;
				max_q[i]    <= '0;
				size_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_d != state_q) wait_q <= 1'b0;
			else if (req.start) wait_q <= 1'b1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				cps_pkg::ST_IDLE: if (in_valid && in_ready) begin
					op_q <= operation; slot_q <= slot;
					sample_q <= cycle_sample; bytes_q <= code_bytes;
				end
				cps_pkg::ST_UPDATE: begin
					status_q <= 1'b0;
					if (op_q == cps_pkg::OP_CLEAR) begin
						loaded_q[slot_q] <= 1'b1;
						size_q[slot_q]   <= bytes_q;
						count_q[slot_q]  <= '0;
						sum_q[slot_q]    <= '0;
						sqsum_q[slot_q]  <= '0;
						min_q[slot_q]    <= '1;
						max_q[slot_q]    <= '0;
					end else if (!loaded_q[slot_q]) begin
						status_q <= 1'b1;
					end else begin
						count_q[slot_q] <= count_q[slot_q] + 64'd1;
						sum_q[slot_q]   <= sum_q[slot_q] + sample_q;
						if (sample_q < min_q[slot_q]) min_q[slot_q] <= sample_q;
						if (sample_q > max_q[slot_q]) max_q[slot_q] <= sample_q;
						gcalls_q <= gcalls_q + 64'd1;
					end
				end
				cps_pkg::ST_SQ_MUL: begin
					tmp_q <= (sample_q[63:32] != '0) ? {mul_p[31:0], 32'b0} : mul_p;
				end
				cps_pkg::ST_SQ_ACC: begin
					if (op_q == cps_pkg::OP_RECORD && status_q == 1'b0) begin
						sqsum_q[slot_q] <= sqsum_q[slot_q] + tmp_q;
						sq_q <= sqsum_q[slot_q] + tmp_q;
					end else begin
						sq_q <= sqsum_q[slot_q];
					end
					cnt_q  <= count_q[slot_q];
					sum_q2 <= sum_q[slot_q];
					mn_q   <= min_q[slot_q];
					mx_q   <= max_q[slot_q];
					sz_q   <= size_q[slot_q];
					mean_q <= '0; sd_q <= '0; cpb_q <= '0; cv_q <= '0; bar_q <= '0;
				end
				cps_pkg::ST_MEAN: if (rsp.done) mean_q <= rsp.result;
				cps_pkg::ST_MSQ:  if (rsp.done) msq_q <= rsp.result;
				cps_pkg::ST_M2:   m2_q <= m2_full;
				cps_pkg::ST_SD:   if (rsp.done) sd_q <= rsp.result[31:0];
				cps_pkg::ST_CPB:  if (rsp.done) cpb_q <= rsp.result;
				cps_pkg::ST_CVMUL: tmp_q <= 64'(sd_q) * 64'(cps_pkg::PERCENT);
				cps_pkg::ST_CV: if (rsp.done) begin
					cv_q <= rsp.result;
					if (!bar_ok) bar_q <= 5'(cps_pkg::BAR_STEPS + 1);
				end
				cps_pkg::ST_BARMUL: tmp_q <= (mean_q - mn_q) * 64'(cps_pkg::BAR_STEPS);
				cps_pkg::ST_BAR: if (rsp.done) begin
					bar_q <= (rsp.result > 64'(cps_pkg::BAR_STEPS)) ?
						5'(cps_pkg::BAR_STEPS) : rsp.result[4:0];
				end
				cps_pkg::ST_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q       <= 1'b1;
					status            <= status_q;
					call_total        <= cnt_q;
					mean_cycles       <= mean_q;
					min_seen          <= mn_q;
					max_seen          <= mx_q;
					std_deviation     <= sd_q;
					cost_per_byte     <= cpb_q;
					variation_percent <= cv_q;
					bar_position      <= bar_q;
					all_calls         <= gcalls_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/cps_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_unit
// shared iterative unit: 64-bit restoring divide or 64-bit floor square root,
// one bit or one result bit per cycle
// ----------------------------------------------------------------------------
module cps_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::unit_req_t req,
	output cps_pkg::unit_rsp_t rsp
);

	logic         busy_q;
	cps_pkg::uop_t op_q;
	logic [6:0]   cnt_q;
	logic [63:0]  num_q;
	logic [63:0]  den_q;
	logic [64:0]  rem_q;
	logic [63:0]  quo_q;
	logic         done_q;

	logic [64:0]  rem_sh;
	logic [64:0]  rem_sub;
	logic [65:0]  sq_rem;
	logic [65:0]  sq_trial;

	always_comb begin
		rem_sh   = {rem_q[63:0], num_q[63]};
		rem_sub  = rem_sh - {1'b0, den_q};
		sq_rem   = {rem_q[63:0], num_q[63:62]};
		sq_trial = sq_rem - {quo_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				num_q  <= req.a;
				den_q  <= req.b;
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= (req.op == cps_pkg::UOP_DIV) ? 7'd64 : 7'd32;
			end else if (busy_q) begin
				if (op_q == cps_pkg::UOP_DIV) begin
					num_q <= {num_q[62:0], 1'b0};
					if (!rem_sub[64]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end else begin
					num_q <= {num_q[61:0], 2'b00};
					if (!sq_trial[65]) begin
						rem_q <= sq_trial[64:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= sq_rem[64:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == cps_pkg::UOP_DIV && den_q == '0) ? '0 : quo_q;

endmodule

FILE: rtl/cps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_checker
// port-level checks for the cycle profile statistics core
// ----------------------------------------------------------------------------
module cps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] call_total,
	input logic [63:0] mean_cycles,
	input logic [4:0]  bar_position
);

	// one item at a time: no new transfer while a result is held
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_cycles))
		else $error("result dropped");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && call_total == '0 |-> mean_cycles == '0 && bar_position == '0)
		else $error("empty slot derived value nonzero");

	a_bar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bar_position <= 5'd21) else $error("bar out of range");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after transfer");

endmodule

bind cycle_profile_statistics_core cps_checker u_cps_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .call_total(call_total),
	.mean_cycles(mean_cycles), .bar_position(bar_position)
);

FILE: sim/tb_cycle_profile_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycle_profile_statistics_core
// self-checking regression of the cycle profile statistics core: directed
// clears and records on the field extremes, then random profiling sequences
// under several idle and stall phases, every result checked against an
// in-bench statistics predictor
// ----------------------------------------------------------------------------
module tb_cycle_profile_statistics_core;

	typedef struct {
		cps_pkg::op_t op;
		logic [3:0]  slot;
		logic [63:0] sample;
		logic [31:0] bytes;
	} prof_item_t;

	typedef struct {
		logic        status;
		logic [63:0] call_total;
		logic [63:0] mean;
		logic [63:0] min_v;
		logic [63:0] max_v;
		logic [31:0] sd;
		logic [63:0] cpb;
		logic [63:0] cv;
		logic [4:0]  bar;
		logic [63:0] all_calls;
	} prof_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [3:0] slot = '0;
	logic [63:0] cycle_sample = '0;
	logic [31:0] code_bytes = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [63:0] call_total, mean_cycles, min_seen, max_seen;
	logic [31:0] std_deviation;
	logic [63:0] cost_per_byte, variation_percent, all_calls;
	logic [4:0] bar_position;

	cycle_profile_statistics_core i_dut (.*);

	logic        loaded_m [cps_pkg::NUM_SLOTS];
	logic [63:0] count_m [cps_pkg::NUM_SLOTS];
	logic [63:0] sum_m [cps_pkg::NUM_SLOTS];
	logic [63:0] sqsum_m [cps_pkg::NUM_SLOTS];
	logic [63:0] min_m [cps_pkg::NUM_SLOTS];
	logic [63:0] max_m [cps_pkg::NUM_SLOTS];
	logic [31:0] size_m [cps_pkg::NUM_SLOTS];
	logic [63:0] calls_m;

	prof_item_t  pending_items[$];
	prof_stats_t expected_stats[$];
	int          errors = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	longint      cycles = 0;

	function automatic logic [31:0] isqrt64(logic [63:0] v);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'h1 << 62;
		while (bit_v > v) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v = v - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res[31:0];
	endfunction

	function automatic prof_stats_t predict_stats(prof_item_t it);
		prof_stats_t r;
		logic [63:0] s, h, msq, m2, var_v;
		int i;
		i = it.slot;
		s = it.sample;
		r = '{default: 0};
		if (it.op == cps_pkg::OP_CLEAR) begin
			loaded_m[i] = 1'b1;
			size_m[i] = it.bytes;
			count_m[i] = 0;
			sum_m[i] = 0;
			sqsum_m[i] = 0;
			min_m[i] = '1;
			max_m[i] = 0;
		end else if (!loaded_m[i]) begin
			r.status = 1'b1;
		end else begin
			count_m[i] += 1;
			sum_m[i] += s;
			if (s[63:32] == 0) begin
				sqsum_m[i] += s * s;
			end else begin
				h = s >> cps_pkg::SCALE_DOWN;
				sqsum_m[i] += (h * h) << cps_pkg::SCALE_UP;
			end
			if (s < min_m[i]) min_m[i] = s;
			if (s > max_m[i]) max_m[i] = s;
			calls_m += 1;
		end
		r.call_total = count_m[i];
		r.min_v = min_m[i];
		r.max_v = max_m[i];
		r.all_calls = calls_m;
		if (count_m[i] != 0) begin
			r.mean = sum_m[i] / count_m[i];
			msq = sqsum_m[i] / count_m[i];
			m2 = r.mean * r.mean;
			var_v = (msq >= m2) ? msq - m2 : 64'd0;
			r.sd = isqrt64(var_v);
			r.cpb = (size_m[i] == 0) ? 64'd0 : r.mean / {32'd0, size_m[i]};
			r.cv = (r.mean == 0) ? 64'd0 : ({32'd0, r.sd} * 64'(cps_pkg::PERCENT)) / r.mean;
			if (r.max_v > r.min_v && r.max_v > 0 && r.mean >= r.min_v
					&& r.mean <= r.max_v) begin
				h = ((r.mean - r.min_v) * 64'(cps_pkg::BAR_STEPS)) / (r.max_v - r.min_v);
				if (h > 64'(cps_pkg::BAR_STEPS)) h = 64'(cps_pkg::BAR_STEPS);
				r.bar = h[4:0];
			end else begin
				r.bar = 5'(cps_pkg::BAR_STEPS + 1);
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return {32'd0, $urandom()};
			1: return {48'd0, 16'($urandom())};
			2: return {$urandom(), $urandom()};
			3: return 64'd1000 + $urandom_range(0, 200);
			4: return {32'd1, $urandom()};
			default: return {8'd0, 24'($urandom()), $urandom()};
		endcase
	endfunction

	task automatic push_item(cps_pkg::op_t op, int sl, logic [63:0] smp, logic [31:0] b);
		prof_item_t it;
		it.op = op;
		it.slot = sl[3:0];
		it.sample = smp;
		it.bytes = b;
		pending_items.push_back(it);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		prof_item_t it;
		if (in_valid && in_ready) begin
			expected_stats.push_back(predict_stats(pending_items.pop_front()));
		end
		if (!(in_valid && !in_ready)) begin
			if (pending_items.size() > 0
					&& ($urandom_range(0, 99) >= send_idle) && arst_n) begin
				it = pending_items[0];
				in_valid <= 1'b1;
				operation <= it.op;
				slot <= it.slot;
				cycle_sample <= it.sample;
				code_bytes <= it.bytes;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		prof_stats_t e;
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (expected_stats.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (status !== e.status) begin
					$error("status exp %0h got %0h", e.status, status); errors++;
				end
				if (call_total !== e.call_total) begin
					$error("call_total exp %0h got %0h", e.call_total, call_total); errors++;
				end
				if (mean_cycles !== e.mean) begin
					$error("mean_cycles exp %0h got %0h", e.mean, mean_cycles); errors++;
				end
				if (min_seen !== e.min_v) begin
					$error("min_seen exp %0h got %0h", e.min_v, min_seen); errors++;
				end
				if (max_seen !== e.max_v) begin
					$error("max_seen exp %0h got %0h", e.max_v, max_seen); errors++;
				end
				if (std_deviation !== e.sd) begin
					$error("std_deviation exp %0h got %0h", e.sd, std_deviation); errors++;
				end
				if (cost_per_byte !== e.cpb) begin
					$error("cost_per_byte exp %0h got %0h", e.cpb, cost_per_byte); errors++;
				end
				if (variation_percent !== e.cv) begin
					$error("variation_percent exp %0h got %0h", e.cv, variation_percent);
					errors++;
				end
				if (bar_position !== e.bar) begin
					$error("bar_position exp %0h got %0h", e.bar, bar_position); errors++;
				end
				if (all_calls !== e.all_calls) begin
					$error("all_calls exp %0h got %0h", e.all_calls, all_calls); errors++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (cycles > 3000000) begin
			$display("cycle_profile_statistics_core regression: fail");
			$finish;
		end
	end

	initial begin
		int ph, k, n, sl;
		for (int i = 0; i < cps_pkg::NUM_SLOTS; i++) begin
			loaded_m[i] = 0; count_m[i] = 0; sum_m[i] = 0; sqsum_m[i] = 0;
			min_m[i] = '1; max_m[i] = 0; size_m[i] = 0;
		end
		calls_m = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unloaded record, extremes, zero size, wrap of sum
		push_item(cps_pkg::OP_RECORD, 3, 64'd5, 32'd0);
		push_item(cps_pkg::OP_CLEAR, 0, 64'd0, 32'd0);
		push_item(cps_pkg::OP_RECORD, 0, 64'd0, 32'd0);
		push_item(cps_pkg::OP_RECORD, 0, 64'd0, 32'd0);
		push_item(cps_pkg::OP_CLEAR, 15, '1, '1);
		push_item(cps_pkg::OP_RECORD, 15, '1, '0);
		push_item(cps_pkg::OP_RECORD, 15, '1, '1);
		push_item(cps_pkg::OP_RECORD, 15, 64'd1, '1);
		push_item(cps_pkg::OP_CLEAR, 1, 64'd0, 32'd7);
		push_item(cps_pkg::OP_RECORD, 1, 64'hFFFF_FFFF, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'h1_0000_0000, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'd10, 32'd0);
		push_item(cps_pkg::OP_CLEAR, 1, 64'd0, 32'd1);
		push_item(cps_pkg::OP_RECORD, 1, 64'd100, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'd100, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'd200, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'h8000_0000_0000_0000, 32'd0);
		push_item(cps_pkg::OP_RECORD, 1, 64'h8000_0000_0000_0000, 32'd0);
		push_item(cps_pkg::OP_CLEAR, 0, 64'd0, 32'd3);

		for (ph = 0; ph < 4; ph++) begin
			wait (pending_items.size() == 0 && expected_stats.size() == 0);
			@(posedge clk);
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 76; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 76; end
				default: begin send_idle = 12; recv_stall = 12; end
			endcase
			n = 0;
			while (n < 170) begin
				sl = $urandom_range(0, cps_pkg::NUM_SLOTS - 1);
				k = $urandom_range(0, 9);
				if (k == 0) begin
					push_item(cps_pkg::OP_RECORD, sl, rand_sample(), $urandom());
				end else if (k < 3) begin
					push_item(cps_pkg::OP_CLEAR, sl, {$urandom(), $urandom()},
						($urandom_range(0, 4) == 0) ? 32'd0 : $urandom());
				end else begin
					push_item(cps_pkg::OP_RECORD, sl, rand_sample(), $urandom());
				end
				n++;
			end
		end
		wait (pending_items.size() == 0 && expected_stats.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("cycle_profile_statistics_core regression: pass");
		end else begin
			$display("cycle_profile_statistics_core regression: fail");
		end
		$finish;
	end
endmodule
